>>> src/page_mapped_flash_translation_assert.svh
// assertion macros for the page mapped flash translation block
`ifndef PAGE_MAPPED_FLASH_TRANSLATION_ASSERT_SVH
`define PAGE_MAPPED_FLASH_TRANSLATION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PMFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PMFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pmft_pkg.sv
// shared types and field constants of the page mapped flash translation block
`timescale 1ns / 1ps
`default_nettype none

package pmft_pkg;

  // request kinds carried in tuser; code three behaves as a lookup
  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_ALLOCATE = 2'd1,
    OP_COMMIT   = 2'd2
  } op_e;

  // fixed field widths
  localparam int unsigned SectorW    = 17;
  localparam int unsigned BlockW     = 10;
  localparam int unsigned PageW      = 6;
  localparam int unsigned OffW       = 2;
  localparam int unsigned EntryW     = 16;
  localparam int unsigned OffFullW   = 3;
  localparam int unsigned InDataW    = 24;
  localparam int unsigned OutDataW   = 40;

  // map entry layout: block above page
  localparam int unsigned EntryPageBits = 6;

endpackage

`default_nettype wire

>>> src/page_mapped_flash_translation.sv
// throughput: one word per cycle when the output is ready and no clearing pass runs,
// with one table read and at most one table write per word
// the sector split and identity location use reciprocal multiplies over two stages
// reset: a clearing pass writes zero to all MAPPED_PAGES table entries, one per cycle;
// tready stays low until that clearing pass has finished after reset is released
// the write pointer resets to the identity location of the last logical page
`timescale 1ns / 1ps
`default_nettype none

module page_mapped_flash_translation #(
  parameter int unsigned MAPPED_PAGES     = 32768,
  parameter int unsigned PAGES_PER_BLOCK  = 64,
  parameter int unsigned BLOCKS_PER_PLANE = 1024,
  parameter int unsigned SECTORS_PER_PAGE = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [16:0] sector_addr, [23:17] zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // [9:0] src_block, [15:10] src_page,
                                           // [17:16] sector_in_page, [27:18] dst_block,
                                           // [33:28] dst_page, [34] erase_needed,
                                           // [35] status, [39:36] zero
);

  localparam int unsigned SW     = pmft_pkg::SectorW;
  localparam int unsigned AddrW  = $clog2(MAPPED_PAGES);
  localparam int unsigned RemW   = 37;
  localparam int unsigned MulW   = SW + 1;
  localparam int unsigned ProdW  = SW + MulW;

  // divisors for logical page, block index and plane index
  localparam int unsigned DivA = SECTORS_PER_PAGE;
  localparam int unsigned DivT = SECTORS_PER_PAGE * PAGES_PER_BLOCK;
  localparam int unsigned DivU = SECTORS_PER_PAGE * PAGES_PER_BLOCK * BLOCKS_PER_PLANE;

  // reciprocals scaled by 2^SW, estimates land at q or q-1
  localparam int unsigned MulA = (32'd1 << SW) / DivA;
  localparam int unsigned MulT = (32'd1 << SW) / DivT;
  localparam int unsigned MulU = (32'd1 << SW) / DivU;

  // write pointer reset: identity location of the last logical page
  localparam int unsigned LastPos  = (MAPPED_PAGES - 1) % (PAGES_PER_BLOCK * BLOCKS_PER_PLANE);
  localparam int unsigned RstBlock = LastPos / PAGES_PER_BLOCK;
  localparam int unsigned RstPage  = LastPos % PAGES_PER_BLOCK;

  // pipeline flow control
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic ok1, ok2, ok3, ok4, ok5;
  logic clr_busy_q;
  logic [AddrW-1:0] clr_cnt_q;
  logic in_fire, s4_load, out_load;

  assign ok5 = !out_v_q || m_axis_tready;
  assign ok4 = !s4_v_q || ok5;
  assign ok3 = !s3_v_q || ok4;
  assign ok2 = !s2_v_q || ok3;
  assign ok1 = !s1_v_q || ok2;

  assign s_axis_tready = ok1 && !clr_busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s4_load       = s3_v_q && ok4;
  assign out_load      = s4_v_q && ok5;

  // stage 1 payload
  pmft_pkg::op_e   s1_op_q;
  logic [SW-1:0]   s1_x_q;

  // stage 2: quotient estimates
  logic [ProdW-1:0] prod_a, prod_t, prod_u;
  logic [SW-1:0]    qa_d, qt_d, qu_d;
  pmft_pkg::op_e    s2_op_q;
  logic [SW-1:0]    s2_x_q, s2_qa_q, s2_qt_q, s2_qu_q;

  assign prod_a = ProdW'(s1_x_q) * ProdW'(MulW'(MulA));
  assign prod_t = ProdW'(s1_x_q) * ProdW'(MulW'(MulT));
  assign prod_u = ProdW'(s1_x_q) * ProdW'(MulW'(MulU));
  assign qa_d   = prod_a[ProdW-2:SW];
  assign qt_d   = prod_t[ProdW-2:SW];
  assign qu_d   = prod_u[ProdW-2:SW];

  // stage 3: one correction step per quotient
  logic [RemW-1:0] rem_a, rem_t, rem_u, off_full;
  logic            ge_a, ge_t, ge_u;
  logic [SW-1:0]   lp_d, t_d, u_d;
  pmft_pkg::op_e   s3_op_q;
  logic [SW-1:0]   s3_lp_q, s3_t_q, s3_u_q;
  logic [pmft_pkg::OffFullW-1:0] s3_off_q;

  assign rem_a    = RemW'(s2_x_q) - RemW'(s2_qa_q) * RemW'(DivA);
  assign rem_t    = RemW'(s2_x_q) - RemW'(s2_qt_q) * RemW'(DivT);
  assign rem_u    = RemW'(s2_x_q) - RemW'(s2_qu_q) * RemW'(DivU);
  assign ge_a     = rem_a >= RemW'(DivA);
  assign ge_t     = rem_t >= RemW'(DivT);
  assign ge_u     = rem_u >= RemW'(DivU);
  assign lp_d     = s2_qa_q + SW'(ge_a);
  assign t_d      = s2_qt_q + SW'(ge_t);
  assign u_d      = s2_qu_q + SW'(ge_u);
  assign off_full = ge_a ? (rem_a - RemW'(DivA)) : rem_a;

  // stage 4: identity location and table read
  logic [SW-1:0]  t_prod, u_prod, pg_diff, blk_diff;
  logic           in_table_d;
  logic [AddrW-1:0] rd_addr;
  pmft_pkg::op_e  s4_op_q;
  logic           s4_in_table_q;
  logic [AddrW-1:0] s4_addr_q;
  logic [pmft_pkg::OffW-1:0]   s4_off_q;
  logic [pmft_pkg::BlockW-1:0] s4_id_blk_q;
  logic [pmft_pkg::PageW-1:0]  s4_id_pg_q;
  logic [pmft_pkg::EntryW-1:0] rd_data_q;
  logic                        fwd_hit_q;
  logic [pmft_pkg::EntryW-1:0] fwd_data_q;

  assign t_prod     = s3_t_q * SW'(PAGES_PER_BLOCK);
  assign u_prod     = s3_u_q * SW'(BLOCKS_PER_PLANE);
  assign pg_diff    = s3_lp_q - t_prod;
  assign blk_diff   = s3_t_q - u_prod;
  assign in_table_d = s3_lp_q < SW'(MAPPED_PAGES);
  assign rd_addr    = s3_lp_q[AddrW-1:0];

  // output stage: source, allocation and pointer update
  logic [pmft_pkg::BlockW-1:0] last_block_q;
  logic [pmft_pkg::PageW-1:0]  last_page_q;
  logic [pmft_pkg::PageW:0]    np_full;
  logic                        wrap;
  logic [pmft_pkg::PageW-1:0]  np;
  logic [pmft_pkg::BlockW:0]   nb;
  logic                        exhausted;
  logic                        is_alloc, is_commit, grant, refuse;
  logic [pmft_pkg::EntryW-1:0] entry;
  logic [pmft_pkg::BlockW-1:0] src_blk, dst_blk;
  logic [pmft_pkg::PageW-1:0]  src_pg, dst_pg;
  logic                        erase;
  logic                        commit_we;
  logic [pmft_pkg::EntryW-1:0] commit_data;
  logic [pmft_pkg::OutDataW-1:0] out_data_q;

  // opcode decode; the unused code reads as a lookup
  always_comb begin
    is_alloc  = 1'b0;
    is_commit = 1'b0;
    case (s4_op_q)
      pmft_pkg::OP_ALLOCATE: begin
        is_alloc = 1'b1;
      end
      pmft_pkg::OP_COMMIT: begin
        is_alloc  = 1'b1;
        is_commit = 1'b1;
      end
      default: begin
        is_alloc  = 1'b0;
        is_commit = 1'b0;
      end
    endcase
  end

  // next free page after the write pointer
  assign np_full   = {1'b0, last_page_q} + 7'd1;
  assign wrap      = np_full >= 7'(PAGES_PER_BLOCK);
  assign np        = wrap ? '0 : np_full[pmft_pkg::PageW-1:0];
  assign nb        = {1'b0, last_block_q} + 11'(wrap);
  assign exhausted = nb >= 11'(BLOCKS_PER_PLANE);
  assign refuse    = is_alloc && (!s4_in_table_q || exhausted);
  assign grant     = is_alloc && !refuse;

  // source location: stored entry, or identity when unmapped
  assign entry   = !s4_in_table_q ? '0 : (fwd_hit_q ? fwd_data_q : rd_data_q);
  assign src_blk = (entry == '0) ? s4_id_blk_q
                 : entry[pmft_pkg::EntryW-1:pmft_pkg::EntryPageBits];
  assign src_pg  = (entry == '0) ? s4_id_pg_q : entry[pmft_pkg::EntryPageBits-1:0];
  assign dst_blk = grant ? nb[pmft_pkg::BlockW-1:0] : '0;
  assign dst_pg  = grant ? np : '0;
  assign erase   = grant && (np == '0);

  assign commit_we   = out_load && is_commit && grant;
  assign commit_data = {nb[pmft_pkg::BlockW-1:0], np};

  // page table with a single write port shared by clearing and commit
  logic [pmft_pkg::EntryW-1:0] page_map_mem [MAPPED_PAGES];
  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic [pmft_pkg::EntryW-1:0] mem_wdata;

  assign mem_we    = clr_busy_q || commit_we;
  assign mem_waddr = clr_busy_q ? clr_cnt_q : s4_addr_q;
  assign mem_wdata = clr_busy_q ? '0 : commit_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      page_map_mem[mem_waddr] <= mem_wdata;
    end
    if (s4_load) begin
      rd_data_q <= page_map_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      s4_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      clr_busy_q   <= 1'b1;
      clr_cnt_q    <= '0;
      last_block_q <= pmft_pkg::BlockW'(RstBlock);
      last_page_q  <= pmft_pkg::PageW'(RstPage);
    end else begin
      if (ok1) s1_v_q  <= in_fire;
      if (ok2) s2_v_q  <= s1_v_q;
      if (ok3) s3_v_q  <= s2_v_q;
      if (ok4) s4_v_q  <= s3_v_q;
      if (ok5) out_v_q <= s4_v_q;
      // clearing sweep after reset
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == AddrW'(MAPPED_PAGES - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      // write pointer advances on commit
      if (commit_we) begin
        last_block_q <= nb[pmft_pkg::BlockW-1:0];
        last_page_q  <= np;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (ok1) begin
      s1_op_q <= pmft_pkg::op_e'(s_axis_tuser);
      s1_x_q  <= s_axis_tdata[SW-1:0];
    end
    if (ok2) begin
      s2_op_q <= s1_op_q;
      s2_x_q  <= s1_x_q;
      s2_qa_q <= qa_d;
      s2_qt_q <= qt_d;
      s2_qu_q <= qu_d;
    end
    if (ok3) begin
      s3_op_q  <= s2_op_q;
      s3_lp_q  <= lp_d;
      s3_t_q   <= t_d;
      s3_u_q   <= u_d;
      s3_off_q <= off_full[pmft_pkg::OffFullW-1:0];
    end
    if (s4_load) begin
      s4_op_q       <= s3_op_q;
      s4_in_table_q <= in_table_d;
      s4_addr_q     <= rd_addr;
      s4_off_q      <= s3_off_q[pmft_pkg::OffW-1:0];
      s4_id_blk_q   <= blk_diff[pmft_pkg::BlockW-1:0];
      s4_id_pg_q    <= pg_diff[pmft_pkg::PageW-1:0];
      // a commit in the same cycle as the read is not seen by the read
      fwd_hit_q     <= commit_we && (s4_addr_q == rd_addr);
      fwd_data_q    <= commit_data;
    end
    if (out_load) begin
      out_data_q <= {4'b0, refuse, erase, dst_pg, dst_blk, s4_off_q, src_pg, src_blk};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  `include "page_mapped_flash_translation_assert.svh"

  `PMFT_ASSERT_NOW(a_no_accept_while_clearing, clr_busy_q, !s_axis_tready,
    "input accepted during table clearing")
  `PMFT_ASSERT_NEXT(a_commit_gives_ok_word, commit_we,
    m_axis_tvalid && !m_axis_tdata[35],
    "commit did not produce an accepted result word")
  `PMFT_ASSERT_NOW(a_refused_has_no_dst, m_axis_tvalid && m_axis_tdata[35],
    (m_axis_tdata[33:18] == 16'd0) && !m_axis_tdata[34],
    "refused word carries a destination")
  `PMFT_ASSERT_NOW(a_pointer_in_plane, 1'b1,
    {1'b0, last_block_q} < 11'(BLOCKS_PER_PLANE),
    "write pointer beyond the plane")

endmodule

`default_nettype wire

>>> sim/pmft_translation_checker.sv
`timescale 1ns / 1ps
// checker that predicts each sector translation and compares the result words
module pmft_translation_checker #(
  parameter int unsigned MAPPED_PAGES     = 32768,
  parameter int unsigned PAGES_PER_BLOCK  = 64,
  parameter int unsigned BLOCKS_PER_PLANE = 1024,
  parameter int unsigned SECTORS_PER_PAGE = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream as seen on the block input
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic [pmft_pkg::InDataW-1:0]  req_data_i,    // [16:0] sector_addr, [23:17] zero
  input  logic [1:0]                    req_user_i,    // [1:0] opcode
  // result stream as seen on the block output
  input  logic                          rsp_valid_i,
  input  logic                          rsp_ready_i,
  input  logic [pmft_pkg::OutDataW-1:0] rsp_data_i,    // src_block, src_page, sector_in_page,
                                                       // dst_block, dst_page, erase_needed,
                                                       // status
  output int unsigned                   err_count_o,
  output int unsigned                   outstanding_o
);

  // result word layout, highest field first
  typedef struct packed {
    logic [3:0]                  pad;
    logic                        status;
    logic                        erase_needed;
    logic [pmft_pkg::PageW-1:0]  dst_page;
    logic [pmft_pkg::BlockW-1:0] dst_block;
    logic [pmft_pkg::OffW-1:0]   sector_in_page;
    logic [pmft_pkg::PageW-1:0]  src_page;
    logic [pmft_pkg::BlockW-1:0] src_block;
  } xlate_t;

  localparam int unsigned PlanePages = PAGES_PER_BLOCK * BLOCKS_PER_PLANE;

  // shadow of the page table and the append pointer
  logic [pmft_pkg::EntryW-1:0] page_table [MAPPED_PAGES];
  int unsigned                 wr_block;
  int unsigned                 wr_page;
  xlate_t                      expected_xlates [$];

  // translate one request and apply its side effects to the shadow state
  function automatic xlate_t translate_sector(input logic [1:0] op,
                                              input logic [pmft_pkg::SectorW-1:0] sector);
    int unsigned                 lpage;
    int unsigned                 in_plane;
    int unsigned                 nxt_blk;
    int unsigned                 nxt_pg;
    logic                        in_table;
    logic [pmft_pkg::EntryW-1:0] entry;
    xlate_t                      r;
    r = '0;
    lpage = sector / SECTORS_PER_PAGE;
    r.sector_in_page = pmft_pkg::OffW'(sector % SECTORS_PER_PAGE);
    in_table = (lpage < MAPPED_PAGES);
    entry = in_table ? page_table[lpage] : '0;
    // zero entry falls back to the page's own place in the plane
    if (entry == '0) begin
      in_plane = lpage % PlanePages;
      r.src_block = pmft_pkg::BlockW'(in_plane / PAGES_PER_BLOCK);
      r.src_page = pmft_pkg::PageW'(in_plane % PAGES_PER_BLOCK);
    end else begin
      r.src_block = entry[pmft_pkg::EntryW-1:pmft_pkg::EntryPageBits];
      r.src_page = entry[pmft_pkg::EntryPageBits-1:0];
    end
    if (op == pmft_pkg::OP_ALLOCATE || op == pmft_pkg::OP_COMMIT) begin
      nxt_blk = wr_block;
      nxt_pg = wr_page + 1;
      if (nxt_pg >= PAGES_PER_BLOCK) begin
        nxt_pg = 0;
        nxt_blk = nxt_blk + 1;
      end
      // refused when out of table or the plane is used up
      if (!in_table || nxt_blk >= BLOCKS_PER_PLANE) begin
        r.status = 1'b1;
      end else begin
        r.dst_block = pmft_pkg::BlockW'(nxt_blk);
        r.dst_page = pmft_pkg::PageW'(nxt_pg);
        r.erase_needed = (nxt_pg == 0);
        if (op == pmft_pkg::OP_COMMIT) begin
          page_table[lpage] = pmft_pkg::EntryW'((nxt_blk << pmft_pkg::EntryPageBits) | nxt_pg);
          wr_block = nxt_blk;
          wr_page = nxt_pg;
        end
      end
    end
    return r;
  endfunction

  // report one field, returns one on a mismatch
  function automatic int unsigned check_field(input string name, input int unsigned want,
                                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // watch both handshakes: retire the oldest prediction, then predict the new request
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned errs;
    int unsigned pushed;
    int unsigned popped;
    xlate_t      want;
    xlate_t      got;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < MAPPED_PAGES; i++) page_table[i] = '0;
      wr_block = ((MAPPED_PAGES - 1) % PlanePages) / PAGES_PER_BLOCK;
      wr_page = ((MAPPED_PAGES - 1) % PlanePages) % PAGES_PER_BLOCK;
      expected_xlates.delete();
      err_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      errs = 0;
      pushed = 0;
      popped = 0;
      if (rsp_valid_i && rsp_ready_i) begin
        got = xlate_t'(rsp_data_i);
        if (expected_xlates.size() == 0) begin
          $display("%0t: result word with none expected, expected none, actual %h",
                   $time, rsp_data_i);
          errs = errs + 1;
        end else begin
          want = expected_xlates.pop_front();
          popped = 1;
          errs += check_field("src_block", 32'(want.src_block), 32'(got.src_block));
          errs += check_field("src_page", 32'(want.src_page), 32'(got.src_page));
          errs += check_field("sector_in_page", 32'(want.sector_in_page),
                              32'(got.sector_in_page));
          errs += check_field("dst_block", 32'(want.dst_block), 32'(got.dst_block));
          errs += check_field("dst_page", 32'(want.dst_page), 32'(got.dst_page));
          errs += check_field("erase_needed", 32'(want.erase_needed),
                              32'(got.erase_needed));
          errs += check_field("status", 32'(want.status), 32'(got.status));
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_xlates.push_back(translate_sector(req_user_i,
                                                   req_data_i[pmft_pkg::SectorW-1:0]));
        pushed = 1;
      end
      err_count_o <= err_count_o + errs;
      outstanding_o <= outstanding_o + pushed - popped;
    end
  end

endmodule

>>> sim/tb_page_mapped_flash_translation.sv
`timescale 1ns / 1ps
// testbench top: drives sector requests and back pressure, and reports the verdict
module tb_page_mapped_flash_translation;

  localparam int unsigned MAPPED_PAGES     = 32768;
  localparam int unsigned PAGES_PER_BLOCK  = 64;
  localparam int unsigned BLOCKS_PER_PLANE = 1024;
  localparam int unsigned SECTORS_PER_PAGE = 4;

  // code three is decoded as a lookup
  localparam logic [1:0]  OP_ALIAS_LOOKUP = 2'd3;
  localparam int unsigned SECTOR_MAX      = (1 << pmft_pkg::SectorW) - 1;
  localparam int unsigned ITEMS_PER_PHASE = 371;
  localparam int unsigned BURST_ITEMS     = 120;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned CYCLE_LIMIT     = 800000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [pmft_pkg::InDataW-1:0]  s_axis_tdata;   // [16:0] sector_addr, [23:17] zero
  logic [1:0]                    s_axis_tuser;   // [1:0] opcode
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [pmft_pkg::OutDataW-1:0] m_axis_tdata;   // [9:0] src_block ... [35] status

  int unsigned                   err_count;
  int unsigned                   outstanding;
  int unsigned                   snd_idle_pct = 0;
  int unsigned                   rcv_idle_pct = 0;
  bit                            hold_go = 1'b0;
  int unsigned                   cycles = 0;
  logic [pmft_pkg::SectorW-1:0]  recent_sectors [$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  page_mapped_flash_translation #(
    .MAPPED_PAGES     (MAPPED_PAGES),
    .PAGES_PER_BLOCK  (PAGES_PER_BLOCK),
    .BLOCKS_PER_PLANE (BLOCKS_PER_PLANE),
    .SECTORS_PER_PAGE (SECTORS_PER_PAGE)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pmft_translation_checker #(
    .MAPPED_PAGES     (MAPPED_PAGES),
    .PAGES_PER_BLOCK  (PAGES_PER_BLOCK),
    .BLOCKS_PER_PLANE (BLOCKS_PER_PLANE),
    .SECTORS_PER_PAGE (SECTORS_PER_PAGE)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .req_user_i    (s_axis_tuser),
    .rsp_valid_i   (m_axis_tvalid),
    .rsp_ready_i   (m_axis_tready),
    .rsp_data_i    (m_axis_tdata),
    .err_count_o   (err_count),
    .outstanding_o (outstanding)
  );

  // offer one request word, with random gaps ahead of it, until accepted
  task automatic send_word(input logic [1:0] op, input logic [pmft_pkg::SectorW-1:0] sector);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {{(pmft_pkg::InDataW - pmft_pkg::SectorW){1'b0}}, sector};
    if (op == pmft_pkg::OP_COMMIT) begin
      recent_sectors.push_back(sector);
      if (recent_sectors.size() > 32) recent_sectors.pop_front();
    end
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // random request, half of them aimed at recently committed pages
  task automatic send_random();
    int unsigned                  pick;
    logic [1:0]                   op;
    logic [pmft_pkg::SectorW-1:0] sector;
    pick = $urandom_range(99);
    if (pick < 35) op = pmft_pkg::OP_LOOKUP;
    else if (pick < 55) op = pmft_pkg::OP_ALLOCATE;
    else if (pick < 92) op = pmft_pkg::OP_COMMIT;
    else op = OP_ALIAS_LOOKUP;
    pick = $urandom_range(9);
    if (recent_sectors.size() != 0 && pick < 5) begin
      sector = recent_sectors[$urandom_range(recent_sectors.size() - 1)];
      sector[pmft_pkg::OffW-1:0] = pmft_pkg::OffW'($urandom_range(3));
    end else if (pick == 5) begin
      sector = $urandom_range(1) ? pmft_pkg::SectorW'(SECTOR_MAX) : '0;
    end else begin
      sector = pmft_pkg::SectorW'($urandom);
    end
    send_word(op, sector);
  endtask

  // stop offering and wait until every result word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // receiver: random ready, with a single long hold when the stimulus asks for it
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("page_mapped_flash_translation regression: fail");
    $finish;
  end

  // stimulus and verdict
  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= pmft_pkg::OP_LOOKUP;
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every opcode, remap and alias lookup
    snd_idle_pct = 13;
    rcv_idle_pct = 81;
    send_word(pmft_pkg::OP_LOOKUP, '0);
    send_word(pmft_pkg::OP_LOOKUP, pmft_pkg::SectorW'(SECTOR_MAX));
    send_word(OP_ALIAS_LOOKUP, pmft_pkg::SectorW'('h15555));
    send_word(pmft_pkg::OP_ALLOCATE, '0);
    send_word(pmft_pkg::OP_COMMIT, pmft_pkg::SectorW'(5));
    send_word(pmft_pkg::OP_LOOKUP, pmft_pkg::SectorW'(6));
    send_word(pmft_pkg::OP_ALLOCATE, pmft_pkg::SectorW'(7));
    send_word(pmft_pkg::OP_COMMIT, pmft_pkg::SectorW'(SECTOR_MAX));
    send_word(pmft_pkg::OP_LOOKUP, pmft_pkg::SectorW'(SECTOR_MAX - 3));
    send_word(OP_ALIAS_LOOKUP, pmft_pkg::SectorW'(4));
    send_word(pmft_pkg::OP_COMMIT, pmft_pkg::SectorW'(5));
    send_word(pmft_pkg::OP_LOOKUP, pmft_pkg::SectorW'(5));
    send_word(pmft_pkg::OP_ALLOCATE, pmft_pkg::SectorW'(SECTOR_MAX));
    send_word(pmft_pkg::OP_LOOKUP, pmft_pkg::SectorW'('h0AAAA));
    send_word(OP_ALIAS_LOOKUP, pmft_pkg::SectorW'(SECTOR_MAX));
    send_word(pmft_pkg::OP_COMMIT, '0);
    send_word(pmft_pkg::OP_LOOKUP, pmft_pkg::SectorW'(2));
    drain();

    // random phases: sender mostly busy, then receiver mostly busy, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 81 : 0;
      rcv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 13 : 0;
      if (phase == 2) begin
        // long receiver hold while requests keep coming
        hold_go = 1'b1;
        repeat (BURST_ITEMS) send_random();
      end
      repeat (ITEMS_PER_PHASE) send_random();
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("page_mapped_flash_translation regression: pass");
    end else begin
      $display("page_mapped_flash_translation regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/pmft_pkg.sv
src/page_mapped_flash_translation.sv
sim/pmft_translation_checker.sv
sim/tb_page_mapped_flash_translation.sv
